// File: rtl/aph_pkg.sv
// Shared types, codes and constants of the playhead timer.
`timescale 1ns / 1ps
package aph_pkg;

  // word field widths
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 24;
  localparam int SPEED_W = 13;
  localparam int MODE_W  = 2;
  localparam int REQ_W   = 2;
  localparam int ENDS_W  = 8;
  localparam int CIDX_W  = 3;

  // magnitude of speed times delta after dropping the fraction bits
  localparam int PROD_W  = SPEED_W + DELTA_W;
  localparam int FRAC_W  = 8;
  localparam int MAG_W   = PROD_W - FRAC_W;

  // signed working width for playhead arithmetic
  localparam int WORK_W  = TIME_W + 3;

  // divider widths
  localparam int DVD_W   = TIME_W + 2;
  localparam int DIV_W   = TIME_W;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_START = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;

  // play modes
  localparam logic [MODE_W-1:0] MODE_ONCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PING = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_CLIP  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_LOW   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HIGH  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SPEED = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_MODE  = 3'd4;

  // register reset values
  localparam logic [TIME_W-1:0]  RST_HIGH  = 32'd3600000000;
  localparam logic [SPEED_W-1:0] RST_SPEED = 13'd256;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/aph_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module aph_div
  import aph_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DIV_W-1:0] acc;
  logic [DVD_W-1:0] qreg;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [DIV_W:0]   acc_sh;
  logic [DIV_W+1:0] diff;
  logic             ge;

  // trial subtract of the shifted partial remainder
  always_comb begin
    acc_sh = {acc, qreg[DVD_W-1]};
    diff   = {1'b0, acc_sh} - {2'b00, dsr};
    ge     = ~diff[DIV_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        acc  <= '0;
        qreg <= req.dividend;
        dsr  <= req.divisor;
        cnt  <= CNT_W'(DVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        acc  <= ge ? diff[DIV_W-1:0] : acc_sh[DIV_W-1:0];
        qreg <= {qreg[DVD_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = qreg;
  assign rsp.rem  = acc;

  // the step counter runs exactly while the divider is busy
  a_busy_cnt: assert property (@(posedge clk) disable iff (rst)
    busy == (cnt != '0))
    else $error("divider counter out of step with busy");

  // completion follows the last step
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == CNT_W'(1) && !req.start) |=> done)
    else $error("divider did not complete");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("divider done while busy");

endmodule

// File: rtl/animation_playhead_timer.sv
// Top level of the playhead timer: registers, sequencer and result register.
// Path: set, start, unused items and idle ticks go from idle through dispatch to done;
//   empty-window ticks add the multiply state, moving ticks multiply, add and compare,
//   wrap or reflect ticks also wait on the bit-serial divider, then fix; a stall holds done.
// Throughput: one item at a time; the next word is taken once the sequencer
//   is back in idle, even while the previous result waits in the output register.
// Reset (rst, synchronous): registers to their defaults, playhead 0,
//   direction flag 0, playing flag 1, output register empty.
`timescale 1ns / 1ps
module animation_playhead_timer
  import aph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,  // [23:0] time_delta, [24] play
  input  logic [REQ_W-1:0]      s_axis_tuser,  // [1:0] req_type
  // result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [47:0]           m_axis_tdata,  // [31:0] lookup_time, [39:32] ends_reached,
                                               // [40] is_playing, [41] going_back
  // register writes
  input  logic                  cfg_we,
  input  logic [CIDX_W-1:0]     cfg_index,
  input  logic [TIME_W-1:0]     cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIX  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  // wrap / reflect kinds
  localparam logic [1:0] K_LOOP_HI = 2'd0;
  localparam logic [1:0] K_LOOP_LO = 2'd1;
  localparam logic [1:0] K_PP_HI   = 2'd2;
  localparam logic [1:0] K_PP_LO   = 2'd3;

  localparam int NCNT_W = DVD_W + 1;

  logic [2:0]          state;

  // configuration
  logic [TIME_W-1:0]   clip_length;
  logic [TIME_W-1:0]   range_low;
  logic [TIME_W-1:0]   range_high;
  logic [SPEED_W-1:0]  speed;
  logic [MODE_W-1:0]   play_mode;

  // playhead state
  logic [TIME_W-1:0]   play_time;
  logic                reverse_flag;
  logic                playing_flag;

  // item and work registers
  logic [REQ_W-1:0]    req;
  logic [DELTA_W-1:0]  delta;
  logic                play_in;
  logic [MAG_W-1:0]    mag;
  logic signed [WORK_W-1:0] t_reg;
  logic [1:0]          kind;
  logic [TIME_W-1:0]   res_time;
  logic [ENDS_W-1:0]   res_ends;

  // output register
  logic [47:0]         out_data;
  logic                out_valid;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // window clamp
  logic [TIME_W-1:0]   lo_c;
  logic [TIME_W-1:0]   hi_c;
  logic [TIME_W-1:0]   hi_m;

  always_comb begin
    lo_c = (range_low > clip_length) ? clip_length : range_low;
    hi_m = (range_high < lo_c) ? lo_c : range_high;
    hi_c = (hi_m > clip_length) ? clip_length : hi_m;
  end

  // step magnitude
  logic                spd_neg;
  logic                spd_zero;
  logic [SPEED_W-1:0]  spd_abs;
  logic [PROD_W-1:0]   prod;

  always_comb begin
    spd_neg  = speed[SPEED_W-1];
    spd_zero = (speed == '0);
    spd_abs  = spd_neg ? (~speed + 1'b1) : speed;
    prod     = PROD_W'(spd_abs) * PROD_W'(delta);
  end

  // playhead sums, all on the signed working width
  logic signed [WORK_W-1:0] lo_s, hi_s, dur_s, pt_s, mag_s, t_sum;
  logic signed [WORK_W-1:0] t_m_hi, t_m_lo, lo_m_t;
  logic                     step_neg;
  logic                     cmp_hi, cmp_lo;

  always_comb begin
    lo_s     = {3'b000, range_low};
    hi_s     = {3'b000, range_high};
    dur_s    = hi_s - lo_s;
    pt_s     = {3'b000, play_time};
    mag_s    = {{(WORK_W-MAG_W){1'b0}}, mag};
    step_neg = (play_mode == MODE_PING) ? reverse_flag : spd_neg;
    t_sum    = step_neg ? (pt_s - mag_s) : (pt_s + mag_s);
    t_m_hi   = t_reg - hi_s;
    t_m_lo   = t_reg - lo_s;
    lo_m_t   = lo_s - t_reg;
    cmp_hi   = (t_reg > hi_s);
    cmp_lo   = (t_reg < lo_s);
  end

  // divider request
  always_comb begin
    div_req.start    = (state == S_CMP) && (play_mode inside {MODE_LOOP, MODE_PING}) &&
                       (cmp_hi || cmp_lo);
    div_req.divisor  = dur_s[DIV_W-1:0];
    if (cmp_hi) begin
      div_req.dividend = (play_mode == MODE_LOOP) ? t_m_hi[DVD_W-1:0] : t_m_lo[DVD_W-1:0];
    end else begin
      div_req.dividend = lo_m_t[DVD_W-1:0];
    end
  end

  aph_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // fold the quotient and remainder back into the window
  logic                rem_nz;
  logic [NCNT_W-1:0]   n_val;
  logic [ENDS_W-1:0]   n_sat;
  logic [TIME_W-1:0]   fix_time;

  always_comb begin
    rem_nz = (div_rsp.rem != '0);
    n_val  = {1'b0, div_rsp.quot} + NCNT_W'(rem_nz) - NCNT_W'(kind == K_PP_HI);
    n_sat  = (|n_val[NCNT_W-1:ENDS_W]) ? {ENDS_W{1'b1}} : n_val[ENDS_W-1:0];
    case (kind)
      K_LOOP_HI: fix_time = rem_nz ? (range_low + div_rsp.rem) : range_high;
      K_LOOP_LO: fix_time = rem_nz ? (range_high - div_rsp.rem) : range_low;
      default:   fix_time = div_rsp.quot[0] ? (range_high - div_rsp.rem)
                                            : (range_low + div_rsp.rem);
    endcase
  end

  logic out_free;
  assign out_free = !out_valid || m_axis_tready;

  // sequencer and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      clip_length  <= '0;
      range_low    <= '0;
      range_high   <= RST_HIGH;
      speed        <= RST_SPEED;
      play_mode    <= MODE_ONCE;
      play_time    <= '0;
      reverse_flag <= 1'b0;
      playing_flag <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLIP:  clip_length <= cfg_data;
          CFG_LOW:   range_low   <= cfg_data;
          CFG_HIGH:  range_high  <= cfg_data;
          CFG_SPEED: speed       <= cfg_data[SPEED_W-1:0];
          CFG_MODE:  play_mode   <= cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req     <= s_axis_tuser;
            delta   <= s_axis_tdata[DELTA_W-1:0];
            play_in <= s_axis_tdata[DELTA_W];
            state   <= S_DISP;
          end
        end

        S_DISP: begin
          res_ends <= '0;
          res_time <= play_time;
          state    <= S_DONE;
          case (req)
            REQ_TICK: begin
              if (playing_flag && !spd_zero) begin
                range_low  <= lo_c;
                range_high <= hi_c;
                state      <= S_MUL;
              end
            end
            REQ_START: begin
              range_low    <= lo_c;
              range_high   <= hi_c;
              play_time    <= spd_neg ? hi_c : lo_c;
              res_time     <= spd_neg ? hi_c : lo_c;
              playing_flag <= 1'b1;
            end
            REQ_SET: begin
              playing_flag <= play_in;
            end
            default: ;
          endcase
        end

        S_MUL: begin
          if (range_high == range_low) begin
            playing_flag <= 1'b0;
            res_time     <= range_low;
            state        <= S_DONE;
          end else begin
            mag   <= prod[PROD_W-1:FRAC_W];
            state <= S_ADD;
          end
        end

        S_ADD: begin
          t_reg <= t_sum;
          state <= S_CMP;
        end

        S_CMP: begin
          state <= S_DONE;
          case (play_mode)
            MODE_ONCE: begin
              if (!spd_neg && t_reg >= hi_s) begin
                play_time    <= range_high;
                res_time     <= range_high;
                playing_flag <= 1'b0;
                res_ends     <= ENDS_W'(1);
              end else if (spd_neg && t_reg <= lo_s) begin
                play_time    <= range_low;
                res_time     <= range_low;
                playing_flag <= 1'b0;
                res_ends     <= ENDS_W'(1);
              end else begin
                play_time <= t_reg[TIME_W-1:0];
                res_time  <= t_reg[TIME_W-1:0];
              end
            end
            MODE_LOOP, MODE_PING: begin
              if (cmp_hi || cmp_lo) begin
                if (play_mode == MODE_LOOP) begin
                  kind <= cmp_hi ? K_LOOP_HI : K_LOOP_LO;
                end else begin
                  kind <= cmp_hi ? K_PP_HI : K_PP_LO;
                end
                state <= S_DIV;
              end else begin
                play_time <= t_reg[TIME_W-1:0];
                res_time  <= t_reg[TIME_W-1:0];
              end
            end
            default: ;
          endcase
        end

        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_FIX;
          end
        end

        S_FIX: begin
          play_time <= fix_time;
          res_time  <= fix_time;
          res_ends  <= n_sat;
          if (kind == K_PP_HI) begin
            reverse_flag <= n_val[0];
          end else if (kind == K_PP_LO) begin
            reverse_flag <= ~n_val[0];
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_free) begin
            out_data  <= {6'b000000, reverse_flag, playing_flag, res_ends, res_time};
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // an accepted word closes the input until its result is formed
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // divider completes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider result with nobody waiting");

  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  // a finished item reaches the output register when it is free
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (m_axis_tvalid && state == S_IDLE))
    else $error("result not loaded");

endmodule
